// ----- design/lkvc_pkg.sv -----
// shared types and constants for the lru key-value cache
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // operation codes carried in tuser
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;
    localparam logic [VAL_W-1:0] SET_VALUE  = '0;

    // one entry as it moves along the recency chain
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             valid;
    } link_t;

endpackage

`default_nettype wire

// ----- design/lru_key_value_cache.sv -----
// lru key-value cache top level: request channel, result channel, capacity register
`timescale 1ns / 1ps
`default_nettype none

// fully associative key-value store with least-recently-used replacement.
// requests arrive on the s_ channel: tuser is the operation (get or set),
// tdata carries key and value. every request gives exactly one result
// transaction on the m_ channel: tuser is the hit flag, tdata the read value
// (stored value on a get hit, all ones on a get miss, zero for any set).
// entries live in a row of cells ordered by recency, position 0 most recent;
// a hit or an insert loads the front cell and shifts the cells in front of
// the hit (or of the free/evicted position) back by one, all in the same cycle.
// the result is held in an output register and appears in the cycle
// after the request is taken; one request per cycle is sustained while the
// receiver keeps m_tready high. while the receiver stalls a new request is
// taken only if that register is empty. reset empties every cell and
// restores cap_reg to 16. capacity is written through cfg_wen/cfg_wdata;
// the user must write it only while idle, which the block does not enforce.
// 0 acts as 1, values above MAX_ENTRIES act as MAX_ENTRIES, and lowering it
// below the occupancy keeps the existing entries.
module lru_key_value_cache
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request: tdata = key [31:0], value [63:32]; tuser = func
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [63:0]                   s_tdata,
    input  wire logic                          s_tuser,
    // result: tdata = read_value [31:0]; tuser = hit
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,
    output logic                               m_tuser,
    // capacity register
    input  wire logic                          cfg_wen,
    input  wire logic [lkvc_pkg::CAP_W-1:0]    cfg_wdata
);

    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

    // request fields
    logic [lkvc_pkg::KEY_W-1:0] req_key;
    logic [lkvc_pkg::VAL_W-1:0] req_value;
    logic                       req_func;
    logic                       accept;

    assign req_key   = s_tdata[lkvc_pkg::KEY_W-1:0];
    assign req_value = s_tdata[lkvc_pkg::KEY_W +: lkvc_pkg::VAL_W];
    assign req_func  = s_tuser;
    assign s_tready  = !m_tvalid || m_tready;
    assign accept    = s_tvalid && s_tready;

    // capacity and occupancy
    logic [lkvc_pkg::CAP_W-1:0] cap_reg;
    logic [OCC_W-1:0]           occ_reg;
    logic [OCC_W-1:0]           occ_next;
    logic [CMP_W-1:0]           cap_ext;
    logic [CMP_W-1:0]           eff_cap;
    logic                       full;

    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > MAX_CMP)
        begin
            eff_cap = MAX_CMP;
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign full = CMP_W'(occ_reg) >= eff_cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (cfg_wen)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // cell chain: link 0 is the incoming entry, link i+1 the output of cell i
    lkvc_pkg::link_t            links [0:MAX_ENTRIES];
    logic [MAX_ENTRIES:0]       carry;
    logic [MAX_ENTRIES-1:0]     match;
    logic                       hit_any;
    logic [lkvc_pkg::VAL_W-1:0] hit_value;
    logic                       front_load;
    logic                       insert;

    assign hit_any = |match;

    // at most one cell matches, so an or of the masked values picks it
    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit_value = hit_value | (match[i] ? links[i+1].value : '0);
        end
    end

    // front cell gets the key with the new value on a set, its own value on a get hit
    assign links[0].key   = req_key;
    assign links[0].value = (req_func == lkvc_pkg::FUNC_SET) ? req_value : hit_value;
    assign links[0].valid = 1'b1;

    assign front_load = accept && ((req_func == lkvc_pkg::FUNC_SET) || hit_any);
    assign carry[0]   = front_load;
    assign insert     = accept && (req_func == lkvc_pkg::FUNC_SET) && !hit_any && !full;

    generate
        for (genvar g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            logic next_valid;

            if (g == MAX_ENTRIES - 1)
            begin : g_end
                assign next_valid = 1'b0;
            end
            else
            begin : g_mid
                assign next_valid = links[g+2].valid;
            end

            lkvc_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .req_key    (req_key),
                .hit_any    (hit_any),
                .full       (full),
                .prev_link  (links[g]),
                .next_valid (next_valid),
                .carry_in   (carry[g]),
                .link       (links[g+1]),
                .match      (match[g]),
                .carry_out  (carry[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        occ_next = occ_reg;
        if (insert)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // result register
    logic                       out_valid_reg;
    logic                       out_hit_reg;
    logic [lkvc_pkg::VAL_W-1:0] out_data_reg;
    logic [lkvc_pkg::VAL_W-1:0] out_data_next;

    always_comb
    begin
        if (req_func == lkvc_pkg::FUNC_SET)
        begin
            out_data_next = lkvc_pkg::SET_VALUE;
        end
        else if (hit_any)
        begin
            out_data_next = hit_value;
        end
        else
        begin
            out_data_next = lkvc_pkg::MISS_VALUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_hit_reg  <= hit_any;
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- design/lkvc_cell.sv -----
// one recency position of the lru chain: holds an entry and shifts it on
`timescale 1ns / 1ps
`default_nettype none

module lkvc_cell
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [lkvc_pkg::KEY_W-1:0]  req_key,
    input  wire logic                        hit_any,
    input  wire logic                        full,
    input  wire lkvc_pkg::link_t             prev_link,
    input  wire logic                        next_valid,
    input  wire logic                        carry_in,
    output lkvc_pkg::link_t                  link,
    output logic                             match,
    output logic                             carry_out
);

    logic                       valid_reg;
    logic [lkvc_pkg::KEY_W-1:0] key_reg;
    logic [lkvc_pkg::VAL_W-1:0] value_reg;
    logic                       stop;

    assign link  = '{key: key_reg, value: value_reg, valid: valid_reg};
    assign match = valid_reg && (key_reg == req_key);

    // chain stops at the hit, at the first free cell, or at the last entry when full
    always_comb
    begin
        if (hit_any)
        begin
            stop = match;
        end
        else if (full)
        begin
            stop = valid_reg && !next_valid;
        end
        else
        begin
            stop = !valid_reg;
        end
    end

    assign carry_out = carry_in && !stop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (carry_in)
        begin
            valid_reg <= prev_link.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (carry_in)
        begin
            key_reg   <= prev_link.key;
            value_reg <= prev_link.value;
        end
    end

endmodule

`default_nettype wire

// ----- design/lkvc_checker.sv -----
// port-level checks for the lru key-value cache, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lkvc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    // every accepted request shows its result in the cycle after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
    else $error("request not answered in the next cycle");

    // any set returns zero as read value
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == lkvc_pkg::FUNC_SET)
        |=> m_tdata == lkvc_pkg::SET_VALUE)
    else $error("set result carries non-zero read value");

    // a miss reads either all ones (get) or zero (set)
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser
        |-> (m_tdata == lkvc_pkg::MISS_VALUE) || (m_tdata == lkvc_pkg::SET_VALUE))
    else $error("miss result with unexpected read value");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
